@@ rtl/http_response_header_parser_assert.svh @@
`ifndef HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HRHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hrhp_pkg.sv @@
package hrhp_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int STATUS_BITS = 10;
  localparam int POS_BITS    = 5;
  localparam int PREFIX_LEN  = 15;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [STATUS_BITS-1:0] STATUS_MAX = STATUS_BITS'(999);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX    = {LENGTH_BITS{1'b1}};
  localparam logic [POS_BITS-1:0]    POS_MAX    = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0]    PREFIX_LAST = POS_BITS'(PREFIX_LEN - 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_FIRST = 4'b0001,
    PH_HEAD  = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    SS_SEEK   = 4'b0001,
    SS_SPACE  = 4'b0010,
    SS_DIGITS = 4'b0100,
    SS_END    = 4'b1000
  } ss_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic                   body_valid;
    logic [7:0]             body_byte;
    logic                   headers_done;
    logic                   complete;
    logic                   status_found;
    logic [STATUS_BITS-1:0] resp_code;
    logic                   length_known;
    logic [LENGTH_BITS-1:0] content_length;
  } out_t;

  // byte plus its character class, as handed from front to back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_space;
  } cls_t;

  function automatic logic [7:0] prefix_char(input logic [POS_BITS-1:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = 8'h43; // C
      5'd1:    c = 8'h6F; // o
      5'd2:    c = 8'h6E; // n
      5'd3:    c = 8'h74; // t
      5'd4:    c = 8'h65; // e
      5'd5:    c = 8'h6E; // n
      5'd6:    c = 8'h74; // t
      5'd7:    c = 8'h2D; // -
      5'd8:    c = 8'h4C; // L
      5'd9:    c = 8'h65; // e
      5'd10:   c = 8'h6E; // n
      5'd11:   c = 8'h67; // g
      5'd12:   c = 8'h74; // t
      5'd13:   c = 8'h68; // h
      5'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/hrhp_front.sv @@
module hrhp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hrhp_pkg::in_t  in_data,
  output logic           push,
  output hrhp_pkg::cls_t push_item,
  input  logic           fifo_full
);
  import hrhp_pkg::*;

  logic       cls_valid_r;
  logic       cls_valid_nxt;
  cls_t       cls_r;
  cls_t       cls_nxt;
  logic       take;
  logic [7:0] b;

  assign push     = cls_valid_r && !fifo_full;
  assign in_stall = cls_valid_r && fifo_full;
  assign take     = in_valid && !in_stall;
  assign b        = in_data.rx_byte;

  always_comb begin
    cls_nxt.rx_byte  = b;
    cls_nxt.start    = in_data.start_req;
    cls_nxt.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    cls_nxt.digit    = 4'(b - CH_ZERO);
    cls_nxt.is_cr    = (b == CH_CR);
    cls_nxt.is_lf    = (b == CH_LF);
    cls_nxt.is_space = (b == CH_SPACE);
  end

  assign cls_valid_nxt = take || (cls_valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_valid_r <= 1'b0;
    end else begin
      cls_valid_r <= cls_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= cls_nxt;
    end
  end

  assign push_item = cls_r;

endmodule

@@ rtl/hrhp_fifo.sv @@
module hrhp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hrhp_pkg::cls_t push_item,
  output logic           full,
  input  logic           pop_ready,
  output logic           pop,
  output hrhp_pkg::cls_t pop_item
);
  import hrhp_pkg::*;

  cls_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r;
  logic [FIFO_CW-1:0] count_nxt;
  logic               empty;

  assign full     = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop      = !empty && pop_ready;
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/hrhp_back.sv @@
module hrhp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop,
  input  hrhp_pkg::cls_t item,
  output logic           pop_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output hrhp_pkg::out_t out_data
);
  import hrhp_pkg::*;

  `include "http_response_header_parser_assert.svh"

  phase_t                 phase_r, phase_nxt;
  logic                   pcr_r, pcr_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic                   pm_r, pm_nxt;
  logic                   inlen_r, inlen_nxt;
  ss_t                    ss_r, ss_nxt;
  logic [STATUS_BITS-1:0] sval_r, sval_nxt;
  logic                   sseen_r, sseen_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   lseen_r, lseen_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r, out_nxt;

  logic [LENGTH_BITS+3:0] len_mul;
  logic [STATUS_BITS+3:0] st_mul;
  logic [POS_BITS-1:0]    pos;
  logic                   bvalid;
  logic                   cmp;
  logic                   empty_line;

  assign pop_ready = !out_valid_r || !out_stall;

  always_comb begin
    phase_nxt  = phase_r;
    pcr_nxt    = pcr_r;
    pos_nxt    = pos_r;
    pm_nxt     = pm_r;
    inlen_nxt  = inlen_r;
    ss_nxt     = ss_r;
    sval_nxt   = sval_r;
    sseen_nxt  = sseen_r;
    len_nxt    = len_r;
    lseen_nxt  = lseen_r;
    rem_nxt    = rem_r;
    bvalid     = 1'b0;
    cmp        = 1'b0;
    empty_line = 1'b0;
    pos        = '0;
    len_mul    = '0;
    st_mul     = '0;

    if (pop) begin
      // start of a new response clears everything first
      if (item.start) begin
        phase_nxt = PH_FIRST;
        pcr_nxt   = 1'b0;
        pos_nxt   = '0;
        pm_nxt    = 1'b1;
        inlen_nxt = 1'b0;
        ss_nxt    = SS_SEEK;
        sval_nxt  = '0;
        sseen_nxt = 1'b0;
        len_nxt   = '0;
        lseen_nxt = 1'b0;
        rem_nxt   = '0;
      end

      len_mul = {1'b0, len_nxt, 3'b000} + {3'b000, len_nxt, 1'b0}
              + {{LENGTH_BITS{1'b0}}, item.digit};
      st_mul  = {1'b0, sval_nxt, 3'b000} + {3'b000, sval_nxt, 1'b0}
              + {{STATUS_BITS{1'b0}}, item.digit};

      case (phase_nxt)
        PH_BODY: begin
          bvalid = 1'b1;
          if (rem_nxt != '0) begin
            rem_nxt = rem_nxt - 1'b1;
          end
          if (rem_nxt == '0) begin
            phase_nxt = PH_DONE;
            cmp       = sseen_nxt;
          end
        end
        PH_DONE: begin
        end
        default: begin
          if (pcr_nxt && item.is_lf) begin
            empty_line = (pos_nxt == POS_BITS'(1));
            pos_nxt    = '0;
            pcr_nxt    = 1'b0;
            pm_nxt     = 1'b1;
            inlen_nxt  = 1'b0;
            if (empty_line) begin
              if (lseen_nxt && (len_nxt != '0)) begin
                phase_nxt = PH_BODY;
                rem_nxt   = len_nxt;
              end else begin
                phase_nxt = PH_DONE;
                cmp       = sseen_nxt;
              end
            end else begin
              phase_nxt = PH_HEAD;
            end
          end else begin
            pos = pos_nxt;
            if (pos_nxt != POS_MAX) begin
              pos_nxt = pos_nxt + 1'b1;
            end
            pcr_nxt = item.is_cr;

            // content-length prefix match and value scan
            if (inlen_nxt) begin
              if (item.is_digit) begin
                len_nxt = (len_mul > {4'b0000, LEN_MAX}) ? LEN_MAX
                                                         : len_mul[LENGTH_BITS-1:0];
                pm_nxt  = 1'b0;
              end else if (!(pm_nxt && item.is_space)) begin
                inlen_nxt = 1'b0;
              end
            end else if (pm_nxt) begin
              if ((pos <= PREFIX_LAST) && (item.rx_byte == prefix_char(pos))) begin
                if (pos == PREFIX_LAST) begin
                  inlen_nxt = 1'b1;
                  lseen_nxt = 1'b1;
                  len_nxt   = '0;
                end
              end else begin
                pm_nxt = 1'b0;
              end
            end

            // status code on the first line only
            if (phase_nxt == PH_FIRST) begin
              case (ss_nxt)
                SS_SEEK: begin
                  if (item.is_space) begin
                    ss_nxt = SS_SPACE;
                  end
                end
                SS_SPACE: begin
                  if (item.is_digit) begin
                    ss_nxt    = SS_DIGITS;
                    sseen_nxt = 1'b1;
                    sval_nxt  = {{(STATUS_BITS-4){1'b0}}, item.digit};
                  end else if (!item.is_space) begin
                    ss_nxt = SS_SEEK;
                  end
                end
                SS_DIGITS: begin
                  if (item.is_digit) begin
                    sval_nxt = (st_mul > {4'b0000, STATUS_MAX}) ? STATUS_MAX
                                                               : st_mul[STATUS_BITS-1:0];
                  end else begin
                    ss_nxt = SS_END;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    out_nxt.body_valid     = bvalid;
    out_nxt.body_byte      = bvalid ? item.rx_byte : 8'h00;
    out_nxt.headers_done   = (phase_nxt == PH_BODY) || (phase_nxt == PH_DONE);
    out_nxt.complete       = cmp;
    out_nxt.status_found   = sseen_nxt;
    out_nxt.resp_code      = sval_nxt;
    out_nxt.length_known   = lseen_nxt;
    out_nxt.content_length = len_nxt;
  end

  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      pcr_r       <= 1'b0;
      pos_r       <= '0;
      pm_r        <= 1'b1;
      inlen_r     <= 1'b0;
      ss_r        <= SS_SEEK;
      sval_r      <= '0;
      sseen_r     <= 1'b0;
      len_r       <= '0;
      lseen_r     <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pcr_r       <= pcr_nxt;
      pos_r       <= pos_nxt;
      pm_r        <= pm_nxt;
      inlen_r     <= inlen_nxt;
      ss_r        <= ss_nxt;
      sval_r      <= sval_nxt;
      sseen_r     <= sseen_nxt;
      len_r       <= len_nxt;
      lseen_r     <= lseen_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `HRHP_ASSERT_NOW(a_complete_has_status, out_valid_r && out_r.complete,
    out_r.status_found, "complete without a status code")
  `HRHP_ASSERT_NOW(a_body_after_headers, out_valid_r && out_r.body_valid,
    out_r.headers_done, "body byte before the header end")
  `HRHP_ASSERT_NOW(a_status_in_range, out_valid_r,
    out_r.resp_code <= STATUS_MAX, "status code above its maximum")
  `HRHP_ASSERT_NEXT(a_done_sticks, pop && !item.start && (phase_r == PH_DONE),
    phase_r == PH_DONE, "left the done phase without a start")

endmodule

@@ rtl/http_response_header_parser.sv @@
// path: a request passes the class register, a queue entry and the result register on its way
//   to out_data, and waits there while out_stall holds
// throughput: one byte per cycle unless stalled; the back end updates all parse state per pop
// reset: synchronous, active-low rst_n clears the queue, the valid flags and the parse
//   state to the first-line, no-status, no-length state; no clearing pass is needed
module http_response_header_parser (
  input  logic           clk,
  input  logic           rst_n,
  // byte stream in
  input  logic           in_valid,
  output logic           in_stall,
  input  hrhp_pkg::in_t  in_data,
  // per-byte parse result out
  output logic           out_valid,
  input  logic           out_stall,
  output hrhp_pkg::out_t out_data
);
  import hrhp_pkg::*;

  // front to queue
  logic push;
  cls_t push_item;
  logic fifo_full;

  // queue to back
  logic pop;
  logic pop_ready;
  cls_t pop_item;

  // front: registers each request and tags it as digit, cr, lf or space
  hrhp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .fifo_full (fifo_full)
  );

  // short queue so the front keeps taking bytes while the back waits on out_stall
  hrhp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop_ready (pop_ready),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  // back: line tracking, status code and content-length scan, body counting,
  // and the result register that carries the outputs
  hrhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .item      (pop_item),
    .pop_ready (pop_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ bench/http_parse_checker.sv @@
`timescale 1ns / 1ps

module http_parse_checker
  import hrhp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   due_count
);

  localparam int MAX_REPORTS = 10;
  localparam logic [8*PREFIX_LEN-1:0] LEN_TAG = "Content-Length:";

  // shadow parse state
  phase_t                 ph;
  ss_t                    ss;
  logic                   prev_cr;
  logic [POS_BITS-1:0]    line_pos;
  logic                   tag_match;
  logic                   in_len;
  logic [STATUS_BITS-1:0] status_val;
  logic                   status_seen;
  logic [LENGTH_BITS-1:0] len_val;
  logic                   len_seen;
  logic [LENGTH_BITS-1:0] body_left;

  out_t results_due[$];

  function automatic void next_line();
    line_pos  = '0;
    prev_cr   = 1'b0;
    tag_match = 1'b1;
    in_len    = 1'b0;
  endfunction

  function automatic void clear_parser();
    ph = PH_FIRST;
    next_line();
    ss          = SS_SEEK;
    status_val  = '0;
    status_seen = 1'b0;
    len_val     = '0;
    len_seen    = 1'b0;
    body_left   = '0;
  endfunction

  function automatic out_t parse_byte(in_t req);
    out_t                   res;
    logic [7:0]             b;
    logic [POS_BITS-1:0]    pos;
    logic [LENGTH_BITS+3:0] len_next;
    logic [STATUS_BITS+3:0] code_next;
    logic                   body;
    logic                   finished;
    logic                   num;
    b        = req.rx_byte;
    body     = 1'b0;
    finished = 1'b0;
    num      = (b >= CH_ZERO) && (b <= CH_NINE);
    if (req.start_req) clear_parser();
    if (ph == PH_BODY) begin
      body = 1'b1;
      if (body_left != 0) body_left = body_left - 1'b1;
      if (body_left == 0) begin
        ph       = PH_DONE;
        finished = status_seen;
      end
    end else if (ph != PH_DONE) begin
      if (prev_cr && b == CH_LF) begin
        // a line holding only the cr ends the headers
        if (line_pos == 1) begin
          if (len_seen && len_val != 0) begin
            ph        = PH_BODY;
            body_left = len_val;
          end else begin
            ph       = PH_DONE;
            finished = status_seen;
          end
        end else begin
          ph = PH_HEAD;
        end
        next_line();
      end else begin
        pos = line_pos;
        if (line_pos != POS_MAX) line_pos = line_pos + 1'b1;
        prev_cr = (b == CH_CR);
        if (in_len) begin
          if (num) begin
            len_next  = (LENGTH_BITS+4)'(len_val) * (LENGTH_BITS+4)'(10)
                      + (LENGTH_BITS+4)'(b - CH_ZERO);
            len_val   = (len_next > LEN_MAX) ? LEN_MAX : len_next[LENGTH_BITS-1:0];
            tag_match = 1'b0;
          end else if (!(tag_match && b == CH_SPACE)) begin
            in_len = 1'b0;
          end
        end else if (tag_match) begin
          if (pos < PREFIX_LEN && b == LEN_TAG[8*(PREFIX_LEN-1-int'(pos)) +: 8]) begin
            if (pos == PREFIX_LAST) begin
              in_len   = 1'b1;
              len_seen = 1'b1;
              len_val  = '0;
            end
          end else begin
            tag_match = 1'b0;
          end
        end
        if (ph == PH_FIRST) begin
          case (ss)
            SS_SEEK: begin
              if (b == CH_SPACE) ss = SS_SPACE;
            end
            SS_SPACE: begin
              if (num) begin
                ss          = SS_DIGITS;
                status_seen = 1'b1;
                status_val  = STATUS_BITS'(b - CH_ZERO);
              end else if (b != CH_SPACE) begin
                ss = SS_SEEK;
              end
            end
            SS_DIGITS: begin
              if (num) begin
                code_next  = (STATUS_BITS+4)'(status_val) * (STATUS_BITS+4)'(10)
                           + (STATUS_BITS+4)'(b - CH_ZERO);
                status_val = (code_next > STATUS_MAX) ? STATUS_MAX
                                                      : code_next[STATUS_BITS-1:0];
              end else begin
                ss = SS_END;
              end
            end
            default: ;
          endcase
        end
      end
    end
    res.body_valid     = body;
    res.body_byte      = body ? b : 8'h00;
    res.headers_done   = (ph == PH_BODY) || (ph == PH_DONE);
    res.complete       = finished;
    res.status_found   = status_seen;
    res.resp_code      = status_val;
    res.length_known   = len_seen;
    res.content_length = len_val;
    return res;
  endfunction

  function automatic string show(out_t r);
    return $sformatf("body %0b/%02h hdr %0b cmp %0b status %0b/%0d len %0b/%0d",
                     r.body_valid, r.body_byte, r.headers_done, r.complete,
                     r.status_found, r.resp_code, r.length_known, r.content_length);
  endfunction

  // sampled mid-cycle, so every value is settled for the coming edge
  always @(negedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_parser();
      results_due.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) results_due.push_back(parse_byte(in_data));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("result with nothing pending: %s", show(out_data));
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (want.body_valid     !== out_data.body_valid   ||
              want.body_byte      !== out_data.body_byte    ||
              want.headers_done   !== out_data.headers_done ||
              want.complete       !== out_data.complete     ||
              want.status_found   !== out_data.status_found ||
              want.resp_code      !== out_data.resp_code    ||
              want.length_known   !== out_data.length_known ||
              want.content_length !== out_data.content_length) begin
            if (fail_count < MAX_REPORTS) begin
              $display("mismatch expected %s", show(want));
              $display("         actual   %s", show(out_data));
            end
            fail_count++;
          end
        end
      end
    end
    due_count = results_due.size();
  end

endmodule

@@ bench/http_response_header_parser_tb.sv @@
`timescale 1ns / 1ps

module http_response_header_parser_tb;
  import hrhp_pkg::*;

  localparam int ITEM_TARGET  = 1950;    // bytes to push through
  localparam int PHASE_LEN    = 250;     // bytes per idling phase
  localparam int HOLD_CYCLES  = 48;      // long receiver hold-off
  localparam int RUN_LIMIT_NS = 400_000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int fail_count;
  int due_count;

  // idling knobs, set per phase by the byte sender
  int idle_pct;
  int stall_pct;
  int holds_wanted;
  int holds_done;
  int hold_cnt;

  int         sent;
  int         phase_idx;
  logic [7:0] resp_bytes[$];   // one response, built before it is sent
  int         want_len;        // body size the built response announces, -1 if huge
  bit         noise_resp;      // response is random bytes with random starts

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  http_response_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  http_parse_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  // hard stop in case the handshake locks up
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // response builder
  // ---------------------------------------------------------------------------

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) resp_bytes.push_back(s[i]);
  endtask

  task automatic add_crlf();
    resp_bytes.push_back(CH_CR);
    resp_bytes.push_back(CH_LF);
  endtask

  task automatic build_response();
    int    n;
    int    cut;
    string tag;
    resp_bytes.delete();
    want_len   = 0;
    noise_resp = ($urandom_range(19) == 0);
    // pure noise: random bytes, starts sprinkled in anywhere
    if (noise_resp) begin
      repeat ($urandom_range(1, 30)) resp_bytes.push_back(8'($urandom));
      return;
    end
    // status line, mostly well formed
    case ($urandom_range(7))
      0: add_text("HTTP/1.0-200");            // no space at all, so no status
      1: add_text("HTTP/1.1 OK 200");         // space then letter, status comes later
      2: begin                                 // length header in the first line
        want_len = $urandom_range(0, 12);
        add_text($sformatf("Content-Length: %0d", want_len));
      end
      3: add_text("HTTP/1.0   404 Not Found"); // run of spaces before the code
      default: begin
        add_text("HTTP/1.0 ");
        // up to four digits, so the code saturates now and then
        repeat ($urandom_range(1, 4)) resp_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        add_text(" OK");
      end
    endcase
    add_crlf();
    // header lines
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(5))
        0, 1: begin
          add_text("Content-Length:");
          repeat ($urandom_range(0, 3)) resp_bytes.push_back(CH_SPACE);
          case ($urandom_range(7))
            0: want_len = 0;                   // empty value
            1: begin                           // far beyond 24 bits, saturates
              add_text("99999999");
              want_len = -1;
            end
            default: begin
              want_len = $urandom_range(0, 20);
              if ($urandom_range(3) == 0) add_text($sformatf("%03d", want_len));
              else add_text($sformatf("%0d", want_len));
            end
          endcase
          // digits after a break in the run must not count, unless the value so far was empty
          if ($urandom_range(3) == 0) add_text(" 7x");
        end
        2: begin
          // near miss: prefix broken at a random position
          tag = "Content-Length:";
          cut = $urandom_range(0, PREFIX_LEN - 1);
          add_text(tag.substr(0, cut - 1));
          resp_bytes.push_back(8'($urandom));
          add_text("12");
        end
        3: repeat ($urandom_range(1, 40)) resp_bytes.push_back(8'($urandom)); // junk, long lines
        4: add_text("content-length: 4");      // wrong case
        default: add_text("Server: x");
      endcase
      add_crlf();
    end
    add_crlf();
    // body, usually exactly the announced size
    if (want_len < 0) n = $urandom_range(0, 6);
    else if ($urandom_range(4) == 0) n = $urandom_range(0, want_len + 3);
    else n = want_len;
    repeat (n) resp_bytes.push_back(8'($urandom));
    // a few trailing bytes after the end get ignored
    repeat ($urandom_range(0, 2)) resp_bytes.push_back(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic s);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, start_req: s};
    taken = 1'b0;
    // in_stall is settled mid-cycle and holds through the next edge
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic send_response(input bit lead_start);
    logic s;
    foreach (resp_bytes[i]) begin
      if (noise_resp) s = ($urandom_range(3) == 0);
      else s = (i == 0) && lead_start;
      send_byte(resp_bytes[i], s);
    end
  endtask

  // stop offering until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    holds_wanted = 0;
    sent         = 0;
    phase_idx    = -1;
    noise_resp   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // status 9, no length: completes at the header end, then extreme bytes are ignored
    resp_bytes = {CH_SPACE, CH_NINE, CH_CR, CH_LF, CH_CR, CH_LF, 8'hFF, 8'h00};
    send_response(1'b1);
    // no status, lone lf and lone cr inside a line: ends without complete
    resp_bytes = {CH_SPACE, 8'h00, CH_LF, CH_CR, 8'h78, CH_CR, CH_LF, CH_CR, CH_LF};
    send_response(1'b1);

    while (sent < ITEM_TARGET) begin
      // new idling phase: drain first, then switch knobs
      if (sent / PHASE_LEN != phase_idx) begin
        phase_idx = sent / PHASE_LEN;
        drain();
        case (phase_idx % 4)
          0: begin
            idle_pct  = 0;
            stall_pct = 0;
            // long hold-off while bytes keep coming, fills the block
            holds_wanted++;
          end
          1: begin
            idle_pct  = 53;
            stall_pct = 0;
          end
          2: begin
            idle_pct  = 0;
            stall_pct = 53;
          end
          default: begin
            idle_pct  = 19;
            stall_pct = 19;
          end
        endcase
      end
      build_response();
      // a missing start now and then runs the next response into the old one
      send_response($urandom_range(15) != 0);
    end

    drain();
    // catch any stray result after the last one due
    repeat (12) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  initial begin
    out_stall  = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_wanted) begin
        holds_done++;
        // stall for a fixed stretch, counted here
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hrhp_pkg.sv
rtl/hrhp_front.sv
rtl/hrhp_fifo.sv
rtl/hrhp_back.sv
rtl/http_response_header_parser.sv
bench/http_parse_checker.sv
bench/http_response_header_parser_tb.sv
